// ===== sv/stv_pkg.sv =====
// stv_pkg: shared types, constants and the quarter-wave sine table function
// for the swept tone voice. No dependencies.

package stv_pkg;

    // Parameter defaults
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF      = 20;

    // Configuration register indexes
    localparam logic [2:0] REG_WAVE_TYPE       = 3'd0;
    localparam logic [2:0] REG_START_INCREMENT = 3'd1;
    localparam logic [2:0] REG_SWEEP_FACTOR    = 3'd2;
    localparam logic [2:0] REG_ATTACK_SAMPLES  = 3'd3;
    localparam logic [2:0] REG_ATTACK_STEP     = 3'd4;
    localparam logic [2:0] REG_DECAY_START     = 3'd5;
    localparam logic [2:0] REG_DECAY_FACTOR    = 3'd6;
    localparam logic [2:0] REG_NOTE_LENGTH     = 3'd7;

    // Waveform codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_SAW      = 2'd2;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

    // Opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Register reset values
    localparam logic [31:0] SWEEP_RESET  = 32'h4000_0000;
    localparam logic [23:0] DECAY_RESET  = 24'hFF_FFFF;
    localparam logic [19:0] LENGTH_RESET = 20'd1;

    // Q0.24 full scale, rounding constant, PCM scale
    localparam logic [23:0] ENV_MAX   = 24'hFF_FFFF;
    localparam logic [40:0] ENV_ROUND = 41'h80_0000;
    localparam logic [14:0] PCM_SCALE = 15'd30000;
    localparam logic [16:0] WAVE_PEAK = 17'd32768;

    typedef struct packed {
        logic [1:0]  wave_type;
        logic [30:0] start_increment;
        logic [31:0] sweep_factor;
        logic [19:0] attack_samples;
        logic [23:0] attack_step;
        logic [23:0] decay_start;
        logic [23:0] decay_factor;
        logic [19:0] note_length;
    } t_cfg;

    // Payload leaving the state stage
    typedef struct packed {
        logic        valid;
        logic        active;
        logic [31:0] phase;
        logic [23:0] env;
        logic [15:0] sine;
        logic [17:0] mix_in;
    } t_stage1;

    // Quarter-wave sine entry k, peak 32768, built from a Q2.30 series
    function automatic logic [15:0] qsin_entry(input int unsigned k,
                                               input int unsigned bits);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] s;
        x = 64'(k) << (30 - bits);
        t = (x * 64'd1686629713) >> 30;
        t2 = (t * t) >> 30;
        r = 64'd1073741824;
        for (int j = 0; j < 5; j++) begin
            q = (t2 * r) >> 30;
            case (j)
                0: q = q / 110;
                1: q = q / 72;
                2: q = q / 42;
                3: q = q / 20;
                default: q = q / 6;
            endcase
            r = 64'd1073741824 - q;
        end
        s = (t * r) >> 30;
        return 16'((s + 64'd16384) >> 15);
    endfunction

endpackage

// ===== sv/stv_voice_state.sv =====
// stv_voice_state: note state (phase, increment, index, envelope) updated
// once per accepted request, plus the sine ROM read. Depends on stv_pkg.

module stv_voice_state #(
    parameter int SINE_TABLE_BITS = stv_pkg::SINE_TABLE_BITS_DEF,
    parameter int COUNT_BITS      = stv_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stv_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  logic             i_opcode,
    input  logic [17:0]      i_mix_in,
    input  logic             i_next_ready,
    output logic             o_ready,
    output stv_pkg::t_stage1 o_s1
);
    import stv_pkg::*;

    localparam int QSIZE = (1 << SINE_TABLE_BITS) + 1;
    localparam int AW    = SINE_TABLE_BITS + 1;

    logic [31:0]           r_phase, n_phase;
    logic [31:0]           r_inc, n_inc;
    logic [COUNT_BITS-1:0] r_idx, n_idx;
    logic [23:0]           r_env, n_env;
    logic                  r_note_on, n_note_on;

    logic                  r_v1;
    logic                  r_active;
    logic [31:0]           r_s1_phase;
    logic [23:0]           r_s1_env;
    logic [15:0]           r_sine;
    logic [17:0]           r_mix_in;

    logic                  w_accept;
    logic                  w_start;
    logic [31:0]           e_phase, e_inc;
    logic [COUNT_BITS-1:0] e_idx, w_len, w_att, w_idx_next;
    logic [23:0]           e_env, w_env_used, w_env_next;
    logic                  e_on, w_active;
    logic [24:0]           w_att_sum;
    logic [47:0]           w_dec_prod;
    logic [63:0]           w_inc_prod;
    logic [31:0]           w_inc_next;
    logic [AW-1:0]         w_addr;
    logic [SINE_TABLE_BITS-1:0] w_qidx;
    logic [15:0]           w_qsin [QSIZE];

    // Constant quarter-wave table
    for (genvar k = 0; k < QSIZE; k++) begin : g_qsin
        assign w_qsin[k] = qsin_entry(k, SINE_TABLE_BITS);
    end

    assign o_ready  = !r_v1 || i_next_ready;
    assign w_accept = i_valid && o_ready;
    assign w_start  = (i_opcode == OP_START);

    // Next note state
    always_comb begin
        e_phase = w_start ? 32'd0 : r_phase;
        e_inc   = w_start ? {1'b0, i_cfg.start_increment} : r_inc;
        e_idx   = w_start ? '0 : r_idx;
        e_env   = w_start ? 24'd0 : r_env;
        e_on    = w_start || r_note_on;
        w_len   = COUNT_BITS'(i_cfg.note_length);
        w_att   = COUNT_BITS'(i_cfg.attack_samples);
        w_active = e_on && (e_idx < w_len);

        w_att_sum  = {1'b0, e_env} + {1'b0, i_cfg.attack_step};
        w_dec_prod = '0;
        if (e_idx < w_att) begin
            w_env_used = e_env;
            w_env_next = w_att_sum[24] ? ENV_MAX : w_att_sum[23:0];
        end else begin
            w_env_used = (e_idx == w_att) ? i_cfg.decay_start : e_env;
            w_dec_prod = 48'(w_env_used) * 48'(i_cfg.decay_factor);
            w_env_next = w_dec_prod[47:24];
        end

        // Exponential sweep, Q2.30, saturating
        w_inc_prod = 64'(e_inc) * 64'(i_cfg.sweep_factor);
        w_inc_next = (|w_inc_prod[63:62]) ? 32'hFFFF_FFFF : w_inc_prod[61:30];
        w_idx_next = e_idx + 1'b1;

        n_phase   = e_phase;
        n_inc     = e_inc;
        n_idx     = e_idx;
        n_env     = e_env;
        n_note_on = 1'b0;
        if (w_active) begin
            n_phase   = e_phase + e_inc;
            n_inc     = w_inc_next;
            n_idx     = w_idx_next;
            n_env     = w_env_next;
            n_note_on = (w_idx_next < w_len);
        end
    end

    // Sine ROM address, mirrored in odd quadrants
    assign w_qidx = n_phase[29 -: SINE_TABLE_BITS];
    assign w_addr = n_phase[30] ? AW'(QSIZE - 1) - {1'b0, w_qidx} : {1'b0, w_qidx};

    // Note state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_inc     <= '0;
            r_idx     <= '0;
            r_env     <= '0;
            r_note_on <= 1'b0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_inc     <= n_inc;
            r_idx     <= n_idx;
            r_env     <= n_env;
            r_note_on <= n_note_on;
        end
    end

    // Stage 1 register and ROM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_active   <= w_active;
            r_s1_phase <= n_phase;
            r_s1_env   <= w_env_used;
            r_mix_in   <= i_mix_in;
            r_sine     <= w_qsin[w_addr];
        end
    end

    assign o_s1 = '{valid: r_v1, active: r_active, phase: r_s1_phase,
                    env: r_s1_env, sine: r_sine, mix_in: r_mix_in};

    // Note state moves only on an accepted request
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_idx) && $stable(r_phase))
        else $error("note state changed without a request");

    // A tick after the note ended yields no voice sample
    a_no_revive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_start && !r_note_on |=> !r_active)
        else $error("voice active after note end");

    // Stage 1 valid only follows an accept when it was free
    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 && !i_valid |=> !r_v1)
        else $error("stage 1 filled without a request");

endmodule

// ===== sv/stv_mix_out.sv =====
// stv_mix_out: waveform shaping and envelope product (stage 2), then mix
// saturation and PCM scaling into the output register. Depends on stv_pkg.

module stv_mix_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_wave_type,
    input  stv_pkg::t_stage1 i_s1,
    output logic             o_ready,
    input  logic             i_m_ready,
    output logic             o_valid,
    output logic [17:0]      o_mix_out,
    output logic [15:0]      o_pcm_out,
    output logic             o_voice_active
);
    import stv_pkg::*;

    logic        r_v2;
    logic        r_neg;
    logic [16:0] r_prod;
    logic [17:0] r_mix_in;
    logic        r_act2;

    logic        r_v3;
    logic [17:0] r_mix_out;
    logic [15:0] r_pcm_out;
    logic        r_active;

    logic        w_ready3;
    logic [16:0] w_mag, w_ramp;
    logic        w_neg;
    logic [31:0] w_tri;
    logic [40:0] w_prod;
    logic [16:0] w_prod_q;

    logic signed [17:0] w_voice;
    logic signed [18:0] w_sum;
    logic signed [17:0] w_sat, w_clamp;
    logic [15:0] w_cmag;
    logic [30:0] w_pcm_prod;
    logic [15:0] w_pcm_mag, w_pcm;

    assign w_ready3 = !r_v3 || i_m_ready;
    assign o_ready  = !r_v2 || w_ready3;

    // Wave magnitude and sign from phase
    always_comb begin
        w_tri = i_s1.phase[31] ? (i_s1.phase - 32'h8000_0000)
                               : (32'h8000_0000 - i_s1.phase);
        w_ramp = (i_wave_type == WAVE_SAW) ? i_s1.phase[31:15] : w_tri[31:15];
        case (i_wave_type)
            WAVE_SINE: begin
                w_mag = {1'b0, i_s1.sine};
                w_neg = i_s1.phase[31];
            end
            WAVE_SQUARE: begin
                w_mag = WAVE_PEAK;
                w_neg = i_s1.phase[31];
            end
            default: begin
                w_neg = (w_ramp < WAVE_PEAK);
                w_mag = w_neg ? (WAVE_PEAK - w_ramp) : (w_ramp - WAVE_PEAK);
            end
        endcase
        w_prod   = 41'(w_mag) * 41'(i_s1.env) + ENV_ROUND;
        w_prod_q = i_s1.active ? w_prod[40:24] : 17'd0;
    end

    // Stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_ready) begin
            r_v2 <= i_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_neg    <= w_neg;
            r_prod   <= w_prod_q;
            r_mix_in <= i_s1.mix_in;
            r_act2   <= i_s1.active;
        end
    end

    // Mix add with saturation, clamp to full scale, PCM scaling
    always_comb begin
        w_voice = r_neg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});
        w_sum   = 19'($signed(r_mix_in)) + 19'(w_voice);
        if (w_sum > 19'sd131071) begin
            w_sat = 18'sd131071;
        end else if (w_sum < -19'sd131072) begin
            w_sat = -18'sd131072;
        end else begin
            w_sat = w_sum[17:0];
        end
        if (w_sat > 18'sd32768) begin
            w_clamp = 18'sd32768;
        end else if (w_sat < -18'sd32768) begin
            w_clamp = -18'sd32768;
        end else begin
            w_clamp = w_sat;
        end
        w_cmag     = w_clamp[17] ? 16'(-w_clamp) : w_clamp[15:0];
        w_pcm_prod = 31'(w_cmag) * 31'(PCM_SCALE);
        w_pcm_mag  = {1'b0, w_pcm_prod[29:15]};
        w_pcm      = w_clamp[17] ? -w_pcm_mag : w_pcm_mag;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_ready3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready3) begin
            r_mix_out <= w_sat;
            r_pcm_out <= w_pcm;
            r_active  <= r_act2;
        end
    end

    assign o_valid        = r_v3;
    assign o_mix_out      = r_mix_out;
    assign o_pcm_out      = r_pcm_out;
    assign o_voice_active = r_active;

    // A stalled stage 2 request is kept
    a_s2_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_ready3 |=> r_v2)
        else $error("stage 2 request lost under stall");

    // PCM stays within the scaled full range
    a_pcm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ($signed(r_pcm_out) <= 16'sd30000 && $signed(r_pcm_out) >= -16'sd30000))
        else $error("pcm sample out of range");

    // Pipeline empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v2 && !r_v3)
        else $error("pipeline not empty after reset");

endmodule

// ===== sv/swept_tone_voice.sv =====
// swept_tone_voice: top level of one synthesizer voice; holds the
// configuration registers and joins stv_voice_state and stv_mix_out (stv_pkg).
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid/s_axis_tready    tdata mix_in, tuser opcode
//   m_axis    out        m_axis_tvalid/m_axis_tready    tdata mix_out,pcm_out; tuser active
//   cfg       in         i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// One request per cycle unless a stalled m_axis backs up the stages; each result passes
// the three register stages after its request (state update, envelope product, mix/PCM stage).
// The note state updates in the accepting cycle, so back-to-back ticks chain.
// Reset (i_rst_n low, synchronous) clears note state, registers and valid bits.
// A stalled m_axis fills the three stages before s_axis_tready drops.

module swept_tone_voice #(
    parameter int SINE_TABLE_BITS = stv_pkg::SINE_TABLE_BITS_DEF,
    parameter int COUNT_BITS      = stv_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [17:0] mix_in, [23:18] zero
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [17:0] mix_out, [33:18] pcm_out, [39:34] zero
    output logic [0:0]  m_axis_tuser,   // [0] voice_active
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import stv_pkg::*;

    t_cfg    r_cfg;
    t_stage1 w_s1;
    logic    w_ready2;
    logic [17:0] w_mix_out;
    logic [15:0] w_pcm_out;
    logic        w_active;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_type       <= WAVE_SINE;
            r_cfg.start_increment <= '0;
            r_cfg.sweep_factor    <= SWEEP_RESET;
            r_cfg.attack_samples  <= '0;
            r_cfg.attack_step     <= '0;
            r_cfg.decay_start     <= '0;
            r_cfg.decay_factor    <= DECAY_RESET;
            r_cfg.note_length     <= LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WAVE_TYPE:       r_cfg.wave_type       <= i_cfg_data[1:0];
                REG_START_INCREMENT: r_cfg.start_increment <= i_cfg_data[30:0];
                REG_SWEEP_FACTOR:    r_cfg.sweep_factor    <= i_cfg_data;
                REG_ATTACK_SAMPLES:  r_cfg.attack_samples  <= i_cfg_data[19:0];
                REG_ATTACK_STEP:     r_cfg.attack_step     <= i_cfg_data[23:0];
                REG_DECAY_START:     r_cfg.decay_start     <= i_cfg_data[23:0];
                REG_DECAY_FACTOR:    r_cfg.decay_factor    <= i_cfg_data[23:0];
                REG_NOTE_LENGTH:     r_cfg.note_length     <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    stv_voice_state #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .i_opcode     (s_axis_tuser[0]),
        .i_mix_in     (s_axis_tdata[17:0]),
        .i_next_ready (w_ready2),
        .o_ready      (s_axis_tready),
        .o_s1         (w_s1)
    );

    stv_mix_out u_mix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wave_type    (r_cfg.wave_type),
        .i_s1           (w_s1),
        .o_ready        (w_ready2),
        .i_m_ready      (m_axis_tready),
        .o_valid        (m_axis_tvalid),
        .o_mix_out      (w_mix_out),
        .o_pcm_out      (w_pcm_out),
        .o_voice_active (w_active)
    );

    assign m_axis_tdata = {6'd0, w_pcm_out, w_mix_out};
    assign m_axis_tuser = w_active;

endmodule

// ===== test/tb_swept_tone_voice.sv =====
`timescale 1ns / 100ps
// tb_swept_tone_voice: self-checking bench for the swept tone voice; drives the sample
// stream and register port, predicts every result in place. Needs stv_pkg and swept_tone_voice.

module tb_swept_tone_voice;
    import stv_pkg::*;

    localparam int TABLE_BITS     = SINE_TABLE_BITS_DEF;
    localparam int QS_SIZE        = (1 << TABLE_BITS) + 1;
    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam int unsigned SERIES_DIV [5] = '{110, 72, 42, 20, 6};

    typedef struct packed {
        logic [17:0] mix;
        logic [15:0] pcm;
        logic        active;
    } t_voice_out;

    // One line of the directed plan: a register write or a sample request
    typedef struct packed {
        logic        is_write;
        logic [2:0]  reg_idx;
        logic [31:0] wdata;
        logic        op;
        logic [17:0] mix;
        logic        typed;
        t_voice_out  want;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [17:0] mix_in, [23:18] zero
    logic [0:0]  s_axis_tuser;   // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [17:0] mix_out, [33:18] pcm_out, [39:34] zero
    logic [0:0]  m_axis_tuser;   // [0] voice_active
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // Register shadow, reset values
    logic [1:0]  cfg_wave        = WAVE_SINE;
    logic [30:0] cfg_start_inc   = '0;
    logic [31:0] cfg_sweep       = 32'h4000_0000;
    logic [19:0] cfg_attack_len  = '0;
    logic [23:0] cfg_attack_step = '0;
    logic [23:0] cfg_decay_start = '0;
    logic [23:0] cfg_decay_mul   = 24'hFF_FFFF;
    logic [19:0] cfg_note_len    = 20'd1;

    // Voice state
    logic [31:0] osc_phase = '0;
    logic [31:0] osc_step  = '0;
    logic [19:0] note_pos  = '0;
    logic [23:0] env_level = '0;
    logic        note_live = 1'b0;

    int unsigned quarter_sine [QS_SIZE];

    t_voice_out awaited_samples [$];
    t_voice_out predicted;
    t_voice_out oldest;
    t_plan_row  offer_row;
    t_plan_row  plan [$];
    logic       offering = 1'b0;
    logic       steady   = 1'b0;
    int         mismatches   = 0;
    int         quiet_cycles = 0;
    int         holds_asked  = 0;
    int         holds_done   = 0;

    swept_tone_voice #(
        .SINE_TABLE_BITS(TABLE_BITS),
        .COUNT_BITS     (COUNT_BITS_DEF)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Quarter-wave sine, Q2.30 odd series, peak 32768
    initial begin : sine_fill
        logic [63:0] x, t, t2, r, s;
        for (int k = 0; k < QS_SIZE; k++) begin
            x  = 64'(k) << (30 - TABLE_BITS);
            t  = (x * 64'd1686629713) >> 30;
            t2 = (t * t) >> 30;
            r  = ONE_Q30;
            for (int j = 0; j < 5; j++)
                r = ONE_Q30 - ((t2 * r) >> 30) / 64'(SERIES_DIV[j]);
            s = (t * r) >> 30;
            quarter_sine[k] = 32'((s + 64'd16384) >> 15);
        end
    end

    function automatic int wave_at(input logic [31:0] ph);
        int unsigned idx, level;
        logic [31:0] fold;
        case (cfg_wave)
            WAVE_SINE: begin
                idx   = (ph >> (30 - TABLE_BITS)) & (QS_SIZE - 2);
                level = ph[30] ? quarter_sine[QS_SIZE - 1 - idx] : quarter_sine[idx];
                return ph[31] ? -int'(level) : int'(level);
            end
            WAVE_SQUARE: return ph[31] ? -32768 : 32768;
            WAVE_SAW:    return int'(ph >> 15) - 32768;
            default: begin
                fold = ph[31] ? ph - 32'h8000_0000 : 32'h8000_0000 - ph;
                return int'(fold >> 15) - 32768;
            end
        endcase
    endfunction

    // Advance the voice by one request and form its output sample
    function automatic t_voice_out advance_voice(input logic op, input logic [17:0] mix_bits);
        int          mix_in, w, voice, sum, clamped;
        int unsigned mag;
        logic [23:0] env;
        logic [63:0] prod, grown;
        t_voice_out  res;
        mix_in     = int'($signed(mix_bits));
        voice      = 0;
        res.active = 1'b0;
        if (op == OP_START) begin
            osc_phase = '0;
            osc_step  = {1'b0, cfg_start_inc};
            note_pos  = '0;
            env_level = '0;
            note_live = 1'b1;
        end
        if (note_live && note_pos < cfg_note_len) begin
            osc_phase = osc_phase + osc_step;
            w = wave_at(osc_phase);
            // linear attack, then geometric decay from decay_start
            if (note_pos < cfg_attack_len) begin
                env       = env_level;
                grown     = 64'(env_level) + 64'(cfg_attack_step);
                env_level = (grown > 64'hFF_FFFF) ? 24'hFF_FFFF : grown[23:0];
            end else begin
                env       = (note_pos == cfg_attack_len) ? cfg_decay_start : env_level;
                grown     = 64'(env) * 64'(cfg_decay_mul);
                env_level = grown[47:24];
            end
            mag   = (w < 0) ? -w : w;
            prod  = (64'(mag) * 64'(env) + 64'h80_0000) >> 24;
            voice = (w < 0) ? -int'(prod) : int'(prod);
            // exponential sweep, saturating
            grown    = (64'(osc_step) * 64'(cfg_sweep)) >> 30;
            osc_step = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
            note_pos = note_pos + 20'd1;
            if (note_pos >= cfg_note_len)
                note_live = 1'b0;
            res.active = 1'b1;
        end else begin
            note_live = 1'b0;
        end
        sum = mix_in + voice;
        if (sum > 131071)  sum = 131071;
        if (sum < -131072) sum = -131072;
        clamped = sum;
        if (clamped > 32768)  clamped = 32768;
        if (clamped < -32768) clamped = -32768;
        mag     = (clamped < 0) ? -clamped : clamped;
        mag     = (mag * 30000) >> 15;
        res.mix = 18'(sum);
        res.pcm = 16'((clamped < 0) ? -int'(mag) : int'(mag));
        return res;
    endfunction

    function automatic t_plan_row reg_row(input logic [2:0] idx, input logic [31:0] value);
        t_plan_row row;
        row          = '0;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.wdata    = value;
        return row;
    endfunction

    function automatic t_plan_row sample_row(input logic op, input logic [17:0] mix);
        t_plan_row row;
        row     = '0;
        row.op  = op;
        row.mix = mix;
        return row;
    endfunction

    // Request whose result is plain to see
    function automatic t_plan_row known_row(input logic op, input logic [17:0] mix,
                                            input logic [17:0] want_mix,
                                            input logic [15:0] want_pcm,
                                            input logic want_active);
        t_plan_row row;
        row       = sample_row(op, mix);
        row.typed = 1'b1;
        row.want  = '{mix: want_mix, pcm: want_pcm, active: want_active};
        return row;
    endfunction

    function automatic logic [17:0] rand_mix();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 18'h1FFFF;
        if (roll == 1) return 18'h20000;
        if (roll < 5)  return 18'($urandom_range(0, 4000)) - 18'd2000;
        return 18'($urandom());
    endfunction

    function automatic logic [31:0] pick_register_value(input logic [2:0] idx);
        int roll;
        roll = $urandom_range(0, 9);
        case (idx)
            REG_WAVE_TYPE: return 32'($urandom_range(0, 3));
            REG_START_INCREMENT: begin
                if (roll == 0) return 32'd0;
                if (roll == 1) return 32'h7FFF_FFFF;
                if (roll < 6)  return 32'($urandom_range(32'h0010_0000, 32'h0800_0000));
                return $urandom() & 32'h7FFF_FFFF;
            end
            REG_SWEEP_FACTOR: begin
                if (roll == 0) return 32'd0;
                if (roll == 1) return 32'hFFFF_FFFF;
                if (roll < 4)  return 32'h4000_0000;
                if (roll < 8)  return 32'h3FC0_0000 + 32'($urandom_range(0, 32'h0080_0000));
                return $urandom();
            end
            REG_ATTACK_SAMPLES: begin
                if (roll == 0) return 32'd0;
                if (roll == 1) return 32'h000F_FFFF;
                if (roll == 2) return $urandom() & 32'h000F_FFFF;
                return 32'($urandom_range(0, 12));
            end
            REG_ATTACK_STEP: begin
                if (roll == 0) return 32'd0;
                if (roll == 1) return 32'h00FF_FFFF;
                if (roll < 6)  return 32'($urandom_range(0, 32'h0020_0000));
                return $urandom() & 32'h00FF_FFFF;
            end
            REG_DECAY_START: begin
                if (roll == 0) return 32'd0;
                if (roll == 1) return 32'h00FF_FFFF;
                return $urandom() & 32'h00FF_FFFF;
            end
            REG_DECAY_FACTOR: begin
                if (roll == 0) return 32'd0;
                if (roll == 1) return 32'h00FF_FFFF;
                if (roll < 8)  return 32'($urandom_range(32'h00E0_0000, 32'h00FF_FFFF));
                return $urandom() & 32'h00FF_FFFF;
            end
            default: begin
                if (roll == 0) return 32'd0;
                if (roll == 1) return 32'd1;
                if (roll == 2)
                    return ($urandom_range(0, 1) == 0) ? 32'h000F_FFFF
                                                      : ($urandom() & 32'h000F_FFFF);
                return 32'($urandom_range(2, 40));
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stop offering requests and wait for every pending result
    task automatic drain_results();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (awaited_samples.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [31:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_WAVE_TYPE:       cfg_wave        = value[1:0];
            REG_START_INCREMENT: cfg_start_inc   = value[30:0];
            REG_SWEEP_FACTOR:    cfg_sweep       = value;
            REG_ATTACK_SAMPLES:  cfg_attack_len  = value[19:0];
            REG_ATTACK_STEP:     cfg_attack_step = value[23:0];
            REG_DECAY_START:     cfg_decay_start = value[23:0];
            REG_DECAY_FACTOR:    cfg_decay_mul   = value[23:0];
            default:             cfg_note_len    = value[19:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one request after an optional gap; returns at the negedge after acceptance
    task automatic send_sample(input t_plan_row row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            if (offering) begin
                s_axis_tvalid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(negedge i_clk);
        end
        offer_row = row;
        s_axis_tdata  <= {6'd0, row.mix};
        s_axis_tuser  <= row.op;
        s_axis_tvalid <= 1'b1;
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Predict on each accepted request, compare each accepted result, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted = advance_voice(s_axis_tuser[0], s_axis_tdata[17:0]);
                awaited_samples.push_back(offer_row.typed ? offer_row.want : predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_samples.size() == 0) begin
                    $display("%0t: unexpected result, mix_out %0d", $time,
                             $signed(m_axis_tdata[17:0]));
                    mismatches++;
                end else begin
                    oldest = awaited_samples.pop_front();
                    check_field("mix_out", int'($signed(oldest.mix)),
                                int'($signed(m_axis_tdata[17:0])));
                    check_field("pcm_out", int'($signed(oldest.pcm)),
                                int'($signed(m_axis_tdata[33:18])));
                    check_field("voice_active", int'(oldest.active), int'(m_axis_tuser[0]));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: random stalls, calm stretches, and long hold-offs on request
    initial begin : result_sink
        int stall_left;
        int calm_left;
        int roll;
        stall_left = 0;
        calm_left  = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (calm_left > 0) begin
                calm_left--;
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 18) begin
                    stall_left = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end else if (roll < 21) begin
                    stall_left = $urandom_range(8, 40);
                    m_axis_tready <= 1'b0;
                end else begin
                    if (roll < 24)
                        calm_left = $urandom_range(20, 80);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Request side: reset, directed plan, random phases, end of run
    initial begin : stimulus
        int   random_sent;
        int   phase_no;
        int   span;
        int   count;
        int   mode;
        logic op;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        offer_row     = '0;
        random_sent   = 0;
        phase_no      = 0;

        plan = '{
            // idle voice passes the mix through
            known_row(OP_TICK, 18'd0, 18'd0, 16'd0, 1'b0),
            known_row(OP_TICK, 18'h1FFFF, 18'h1FFFF, 16'd30000, 1'b0),
            known_row(OP_TICK, 18'h20000, 18'h20000, -16'sd30000, 1'b0),
            // reset registers: one-sample note with zero envelope
            known_row(OP_START, 18'd0, 18'd0, 16'd0, 1'b1),
            // zero note length: start gives no voice sample
            reg_row(REG_NOTE_LENGTH, 32'd0),
            known_row(OP_START, 18'd0, 18'd0, 16'd0, 1'b0),
            known_row(OP_TICK, 18'd0, 18'd0, 16'd0, 1'b0),
            // extremes: envelope and increment saturation, mix saturation
            reg_row(REG_WAVE_TYPE, 32'(WAVE_SQUARE)),
            reg_row(REG_START_INCREMENT, 32'h7FFF_FFFF),
            reg_row(REG_SWEEP_FACTOR, 32'hFFFF_FFFF),
            reg_row(REG_ATTACK_SAMPLES, 32'd3),
            reg_row(REG_ATTACK_STEP, 32'h00FF_FFFF),
            reg_row(REG_DECAY_START, 32'h00FF_FFFF),
            reg_row(REG_DECAY_FACTOR, 32'd0),
            reg_row(REG_NOTE_LENGTH, 32'd8),
            sample_row(OP_START, 18'h1FFFF),
            sample_row(OP_TICK, 18'h20000),
            sample_row(OP_TICK, 18'd0),
            sample_row(OP_TICK, 18'd100),
            sample_row(OP_TICK, 18'h3FF00),
            // wave changes in the middle of a note, then past its end
            reg_row(REG_WAVE_TYPE, 32'(WAVE_SAW)),
            sample_row(OP_TICK, 18'd0),
            sample_row(OP_TICK, 18'd0),
            reg_row(REG_WAVE_TYPE, 32'(WAVE_TRIANGLE)),
            sample_row(OP_TICK, 18'd0),
            sample_row(OP_TICK, 18'd0),
            // sine note with decay only
            reg_row(REG_WAVE_TYPE, 32'(WAVE_SINE)),
            reg_row(REG_SWEEP_FACTOR, 32'h4000_0000),
            reg_row(REG_DECAY_FACTOR, 32'h00F0_0000),
            reg_row(REG_ATTACK_SAMPLES, 32'd0),
            reg_row(REG_DECAY_START, 32'h0080_0000),
            reg_row(REG_START_INCREMENT, 32'h0100_0000),
            sample_row(OP_START, 18'd0),
            sample_row(OP_TICK, 18'd0),
            sample_row(OP_TICK, 18'h00FFF),
            sample_row(OP_TICK, 18'd0),
            sample_row(OP_TICK, 18'h3F000),
            sample_row(OP_TICK, 18'd0),
            // longest note and attack
            reg_row(REG_NOTE_LENGTH, 32'h000F_FFFF),
            reg_row(REG_ATTACK_SAMPLES, 32'h000F_FFFF),
            sample_row(OP_START, 18'd0),
            sample_row(OP_TICK, 18'd0),
            sample_row(OP_TICK, 18'd0)
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_write)
                set_register(plan[i].reg_idx, plan[i].wdata);
            else
                send_sample(plan[i]);
        end

        // Random phases: new settings, then a note, the rest of a note, or noise
        while (random_sent < RANDOM_ITEMS) begin
            drain_results();
            steady = ($urandom_range(0, 3) == 0);
            for (int r = 0; r < 8; r++)
                if (phase_no == 0 || $urandom_range(0, 2) == 0)
                    set_register(3'(r), pick_register_value(3'(r)));
            span  = (cfg_note_len < 20'd40) ? int'(cfg_note_len) : 40;
            count = $urandom_range(1, span + 5);
            mode  = $urandom_range(0, 3);
            if (phase_no % 20 == 4) begin
                // back-pressure: the result side holds off while requests keep coming
                holds_asked++;
                steady = 1'b1;
                count  = 24;
                mode   = 2;
            end
            for (int k = 0; k < count; k++) begin
                if (mode == 0)
                    op = 1'($urandom_range(0, 1));
                else
                    op = (k == 0 && mode != 1) ? OP_START : OP_TICK;
                send_sample(sample_row(op, rand_mix()));
                random_sent++;
            end
            phase_no++;
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
